>>> rtl/mdpc_pkg.sv
// Shared constants, types and helpers for the mecanum drive PI controller.
package mdpc_pkg;

   localparam int FRAC_BITS_DEF = 12;

   // configuration register indexes
   localparam logic [2:0] REG_PROP   = 3'd0;
   localparam logic [2:0] REG_INTEG  = 3'd1;
   localparam logic [2:0] REG_GEOM   = 3'd2;
   localparam logic [2:0] REG_STEP   = 3'd3;
   localparam logic [2:0] REG_LIMIT  = 3'd4;
   localparam logic [2:0] REG_FSCALE = 3'd5;

   localparam logic [15:0] PROP_RST   = 16'd300;
   localparam logic [15:0] INTEG_RST  = 16'd300;
   localparam logic [14:0] GEOM_RST   = 15'd1638;
   localparam logic [11:0] STEP_RST   = 12'd41;
   localparam logic [14:0] LIMIT_RST  = 15'd2048;
   localparam logic [15:0] FSCALE_RST = 16'd7199;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] integ_gain;
      logic [14:0] geometry_sum;
      logic [11:0] smooth_step;
      logic [14:0] wheel_limit;
      logic [15:0] pwm_full_scale;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       load;     // capture inputs
      logic       smooth;   // smooth axis sel
      logic       rot_mul;  // multiply vz by geometry
      logic       kin;      // wheel targets
      logic       pi_mul;   // gain products for wheel sel
      logic       pi_acc;   // accumulate wheel sel
      logic [1:0] sel;
   } cmd_type;

endpackage

>>> rtl/mecanum_drive_pi_controller.sv
// Top level of the mecanum drive PI controller: CSR block, sequencer and datapath.
// One request beat is one control tick. It is taken in, the three body axes are
// smoothed one per cycle, vz is scaled by the geometry, wheel targets are formed
// and clamped, and the four PI loops then run through one shared pair of
// multipliers, a multiply step and an accumulate step for each wheel. The block
// takes the next request the cycle after the result beat is taken, so no new
// request is accepted while a tick is in progress. Registers must be written over
// the APB port only while idle; the block itself does not enforce this.
module mecanum_drive_pi_controller
   import mdpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_target_vx,
   input  logic signed [15:0] req_target_vy,
   input  logic signed [15:0] req_target_vz,
   input  logic signed [15:0] req_speed_a,
   input  logic signed [15:0] req_speed_b,
   input  logic signed [15:0] req_speed_c,
   input  logic signed [15:0] req_speed_d,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_cmp_a1,
   output logic [15:0]        rsp_cmp_a2,
   output logic [15:0]        rsp_cmp_b1,
   output logic [15:0]        rsp_cmp_b2,
   output logic [15:0]        rsp_cmp_c1,
   output logic [15:0]        rsp_cmp_c2,
   output logic [15:0]        rsp_cmp_d1,
   output logic [15:0]        rsp_cmp_d2,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   cfg_type cfg_ff;
   cmd_type cmd;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   // register file, byte address 4*index
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= PROP_RST;
         cfg_ff.integ_gain     <= INTEG_RST;
         cfg_ff.geometry_sum   <= GEOM_RST;
         cfg_ff.smooth_step    <= STEP_RST;
         cfg_ff.wheel_limit    <= LIMIT_RST;
         cfg_ff.pwm_full_scale <= FSCALE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (reg_idx)
            REG_PROP:   cfg_ff.prop_gain      <= csr_pwdata[15:0];
            REG_INTEG:  cfg_ff.integ_gain     <= csr_pwdata[15:0];
            REG_GEOM:   cfg_ff.geometry_sum   <= csr_pwdata[14:0];
            REG_STEP:   cfg_ff.smooth_step    <= csr_pwdata[11:0];
            REG_LIMIT:  cfg_ff.wheel_limit    <= csr_pwdata[14:0];
            REG_FSCALE: cfg_ff.pwm_full_scale <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PROP:   csr_prdata = 32'(cfg_ff.prop_gain);
         REG_INTEG:  csr_prdata = 32'(cfg_ff.integ_gain);
         REG_GEOM:   csr_prdata = 32'(cfg_ff.geometry_sum);
         REG_STEP:   csr_prdata = 32'(cfg_ff.smooth_step);
         REG_LIMIT:  csr_prdata = 32'(cfg_ff.wheel_limit);
         REG_FSCALE: csr_prdata = 32'(cfg_ff.pwm_full_scale);
         default:    csr_prdata = '0;
      endcase
   end

   mdpc_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   mdpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .cfg(cfg_ff),
      .target_vx(req_target_vx), .target_vy(req_target_vy), .target_vz(req_target_vz),
      .speed_a(req_speed_a), .speed_b(req_speed_b),
      .speed_c(req_speed_c), .speed_d(req_speed_d),
      .cmp_a1(rsp_cmp_a1), .cmp_a2(rsp_cmp_a2), .cmp_b1(rsp_cmp_b1), .cmp_b2(rsp_cmp_b2),
      .cmp_c1(rsp_cmp_c1), .cmp_c2(rsp_cmp_c2), .cmp_d1(rsp_cmp_d1), .cmp_d2(rsp_cmp_d2)
   );
endmodule

>>> rtl/mdpc_datapath.sv
// Datapath: smoothing, kinematics and shared-multiplier PI loops.
module mdpc_datapath
   import mdpc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic signed [15:0] target_vx,
   input  logic signed [15:0] target_vy,
   input  logic signed [15:0] target_vz,
   input  logic signed [15:0] speed_a,
   input  logic signed [15:0] speed_b,
   input  logic signed [15:0] speed_c,
   input  logic signed [15:0] speed_d,
   output logic [15:0]        cmp_a1,
   output logic [15:0]        cmp_a2,
   output logic [15:0]        cmp_b1,
   output logic [15:0]        cmp_b2,
   output logic [15:0]        cmp_c1,
   output logic [15:0]        cmp_c2,
   output logic [15:0]        cmp_d1,
   output logic [15:0]        cmp_d2
);
   localparam int AW = 16 + FRAC_BITS + 2; // accumulator width
   localparam int SW = 40;                 // PI sum: accumulator plus both products

   logic signed [15:0] tgt_ff [3];
   logic signed [15:0] spd_ff [4];
   logic signed [16:0] sv_ff [3];
   logic signed [16:0] sv_in;
   logic signed [31:0] rotp_ff;
   logic signed [17:0] wt_ff [4];
   logic signed [AW-1:0] acc_ff [4];
   logic signed [AW-1:0] acc_in;
   logic signed [17:0] perr_ff [4];
   logic signed [35:0] pp_ff, ip_ff;
   logic signed [17:0] err_ff;
   logic signed [17:0] drv_ff [4];

   // smoothing of selected axis
   logic signed [16:0] s_cur, s_mag, s_v;
   logic signed [15:0] s_t;
   always_comb begin
      s_cur = sv_ff[cmd.sel];
      s_t   = tgt_ff[cmd.sel];
      s_mag = (s_t < 0) ? -17'(s_t) : 17'(s_t);
      // zero target: the clamp bound is zero, so the 0.9 decay never shows
      if (s_t > 0)      s_v = s_cur + 17'($signed({1'b0, cfg.smooth_step}));
      else if (s_t < 0) s_v = s_cur - 17'($signed({1'b0, cfg.smooth_step}));
      else              s_v = '0;
      if (s_v > s_mag)       sv_in = s_mag;
      else if (s_v < -s_mag) sv_in = -s_mag;
      else                   sv_in = s_v;
   end

   // kinematics
   logic signed [31:0] rot_t;
   logic signed [19:0] rot, k_vx, k_vy, k_lim;
   logic signed [19:0] k_raw [4];
   always_comb begin
      rot_t = rotp_ff + ((rotp_ff < 0) ? 32'((33'sd1 <<< FRAC_BITS) - 33'sd1) : 32'sd0);
      rot   = 20'(rot_t >>> FRAC_BITS);
      k_vx  = 20'(sv_ff[0]);
      k_vy  = 20'(sv_ff[1]);
      k_lim = 20'($signed({1'b0, cfg.wheel_limit}));
      k_raw[0] = k_vx + k_vy - rot;
      k_raw[1] = k_vx - k_vy - rot;
      k_raw[2] = k_vx + k_vy + rot;
      k_raw[3] = k_vx - k_vy + rot;
   end

   // PI error for selected wheel
   logic signed [17:0] e_now, e_diff;
   assign e_now  = wt_ff[cmd.sel] - 18'(spd_ff[cmd.sel]);
   assign e_diff = e_now - perr_ff[cmd.sel];

   logic signed [SW-1:0] a_sum, a_top;
   logic signed [AW:0]   a_t;
   logic signed [AW-1:0] a_div;
   always_comb begin
      a_sum = SW'(acc_ff[cmd.sel]) + SW'(pp_ff) + SW'(ip_ff);
      a_top = SW'($signed({1'b0, cfg.pwm_full_scale})) <<< FRAC_BITS;
      if (a_sum > a_top)       acc_in = AW'(a_top);
      else if (a_sum < -a_top) acc_in = AW'(-a_top);
      else                     acc_in = AW'(a_sum);
      a_t   = (AW+1)'(acc_in) +
              ((acc_in < 0) ? (AW+1)'((1 <<< FRAC_BITS) - 1) : (AW+1)'(0));
      a_div = AW'(a_t >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) sv_ff[i] <= '0;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i]  <= '0;
            perr_ff[i] <= '0;
            drv_ff[i]  <= '0;
         end
      end else begin
         if (cmd.load) begin
            tgt_ff[0] <= target_vx; tgt_ff[1] <= target_vy; tgt_ff[2] <= target_vz;
            spd_ff[0] <= speed_a; spd_ff[1] <= speed_b;
            spd_ff[2] <= speed_c; spd_ff[3] <= speed_d;
         end
         if (cmd.smooth) sv_ff[cmd.sel] <= sv_in;
         if (cmd.rot_mul) rotp_ff <= 32'(sv_ff[2]) * 32'($signed({1'b0, cfg.geometry_sum}));
         if (cmd.kin)
            for (int i = 0; i < 4; i++)
               wt_ff[i] <= (k_raw[i] > k_lim) ? 18'(k_lim) :
                           (k_raw[i] < -k_lim) ? 18'(-k_lim) : 18'(k_raw[i]);
         if (cmd.pi_mul) begin
            pp_ff  <= 36'(e_diff) * 36'($signed({1'b0, cfg.prop_gain}));
            ip_ff  <= 36'(e_now) * 36'($signed({1'b0, cfg.integ_gain}));
            err_ff <= e_now;
         end
         if (cmd.pi_acc) begin
            acc_ff[cmd.sel]  <= acc_in;
            perr_ff[cmd.sel] <= err_ff;
            drv_ff[cmd.sel]  <= (cmd.sel == 2'd1 || cmd.sel == 2'd2) ? -18'(a_div) : 18'(a_div);
         end
      end
   end

   // bridge mapping
   logic [15:0] b1 [4], b2 [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (drv_ff[i] < 0) begin
            b1[i] = cfg.pwm_full_scale;
            b2[i] = cfg.pwm_full_scale + drv_ff[i][15:0];
         end else begin
            b2[i] = cfg.pwm_full_scale;
            b1[i] = cfg.pwm_full_scale - drv_ff[i][15:0];
         end
      end
   end
   assign cmp_a1 = b1[0]; assign cmp_a2 = b2[0];
   assign cmp_b1 = b1[1]; assign cmp_b2 = b2[1];
   assign cmp_c1 = b1[2]; assign cmp_c2 = b2[2];
   assign cmp_d1 = b1[3]; assign cmp_d2 = b2[3];
endmodule

>>> rtl/mdpc_control.sv
// Sequencer stepping the datapath through one control tick.
module mdpc_control
   import mdpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SMTH = 4'd1;
   localparam logic [3:0] ST_ROT  = 4'd2;
   localparam logic [3:0] ST_KIN  = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_ACC  = 4'd5;
   localparam logic [3:0] ST_OUT  = 4'd6;

   logic [3:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1; state_in = ST_SMTH; sel_in = '0;
         end
         ST_SMTH: begin
            cmd.smooth = 1'b1;
            if (sel_ff == 2'd2) begin state_in = ST_ROT; sel_in = '0; end
            else sel_in = sel_ff + 2'd1;
         end
         ST_ROT: begin cmd.rot_mul = 1'b1; state_in = ST_KIN; end
         ST_KIN: begin cmd.kin = 1'b1; state_in = ST_MUL; end
         ST_MUL: begin cmd.pi_mul = 1'b1; state_in = ST_ACC; end
         ST_ACC: begin
            cmd.pi_acc = 1'b1;
            if (sel_ff == 2'd3) state_in = ST_OUT;
            else begin state_in = ST_MUL; sel_in = sel_ff + 2'd1; end
         end
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

>>> rtl/mdpc_checker.sv
// Port-level checks for the mecanum drive PI controller, bound to the top level.
module mdpc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [15:0] rsp_cmp_a1,
   input logic csr_pready
);
   // no new request is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with result pending");
   // an accepted request is not immediately followed by a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cmp_a1)))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind mecanum_drive_pi_controller mdpc_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_cmp_a1, .csr_pready
);

>>> tb/mecanum_drive_pi_controller_tb.sv
// Self-checking testbench for the mecanum drive PI controller.
module mecanum_drive_pi_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mdpc_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // request channel
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_target_vx = '0, req_target_vy = '0, req_target_vz = '0;
   logic signed [15:0] req_speed_a = '0, req_speed_b = '0, req_speed_c = '0, req_speed_d = '0;
   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_cmp_a1, rsp_cmp_a2, rsp_cmp_b1, rsp_cmp_b2;
   logic [15:0] rsp_cmp_c1, rsp_cmp_c2, rsp_cmp_d1, rsp_cmp_d2;
   // CSR port
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mecanum_drive_pi_controller u_top (.*);

   typedef struct {
      logic [15:0] cmp [8];
   } pwm_beat_type;

   pwm_beat_type pwm_expected [$];
   int        n_errors = 0;
   bit        idle_on = 1'b1;  // random idling enable, both sides

   // shadow copy of the controller state and registers
   logic [15:0] m_prop, m_integ, m_fs;
   logic [14:0] m_geom, m_limit;
   logic [11:0] m_step;
   longint      m_sv [3];
   longint      m_acc [4];
   longint      m_perr [4];

   function automatic longint clip(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic void model_reset();
      m_prop = PROP_RST; m_integ = INTEG_RST; m_geom = GEOM_RST;
      m_step = STEP_RST; m_limit = LIMIT_RST; m_fs = FSCALE_RST;
      foreach (m_sv[i]) m_sv[i] = 0;
      foreach (m_acc[i]) begin
         m_acc[i] = 0;
         m_perr[i] = 0;
      end
   endfunction

   function automatic longint wheel_loop(int w, longint tgt, longint spd);
      longint top, e, acc;
      top = longint'(m_fs) <<< FRAC;
      e = tgt - spd;
      acc = m_acc[w] + longint'(m_prop) * (e - m_perr[w]) + longint'(m_integ) * e;
      acc = clip(acc, -top, top);
      m_acc[w] = acc;
      m_perr[w] = e;
      return acc / (longint'(1) <<< FRAC);  // truncates toward zero
   endfunction

   // one control tick: smoothing, kinematics, PI, bridge mapping
   function automatic pwm_beat_type predict_pwm(longint t[3], longint spd[4]);
      pwm_beat_type r;
      longint v, mag, rot, lim, fs;
      longint wt [4];
      longint drv [4];
      for (int i = 0; i < 3; i++) begin
         v = m_sv[i];
         mag = (t[i] < 0) ? -t[i] : t[i];
         if (t[i] > 0) v += m_step;
         else if (t[i] < 0) v -= m_step;
         else v = (v * 9) / 10;
         m_sv[i] = clip(v, -mag, mag);
      end
      rot = (m_sv[2] * longint'(m_geom)) / (longint'(1) <<< FRAC);
      lim = m_limit;
      wt[0] = clip(m_sv[0] + m_sv[1] - rot, -lim, lim);
      wt[1] = clip(m_sv[0] - m_sv[1] - rot, -lim, lim);
      wt[2] = clip(m_sv[0] + m_sv[1] + rot, -lim, lim);
      wt[3] = clip(m_sv[0] - m_sv[1] + rot, -lim, lim);
      for (int w = 0; w < 4; w++) drv[w] = wheel_loop(w, wt[w], spd[w]);
      drv[1] = -drv[1];  // wheels B and C are mounted reversed
      drv[2] = -drv[2];
      fs = m_fs;
      for (int w = 0; w < 4; w++) begin
         if (drv[w] < 0) begin
            r.cmp[2*w] = fs[15:0];
            r.cmp[2*w+1] = 16'(fs + drv[w]);
         end else begin
            r.cmp[2*w] = 16'(fs - drv[w]);
            r.cmp[2*w+1] = fs[15:0];
         end
      end
      return r;
   endfunction

   function automatic bit gap();
      return idle_on && ($urandom_range(99) < 32);
   endfunction

   // send one tick and queue its expected compare values
   task automatic send_tick(logic [15:0] vx, vy, vz, sa, sb, sc, sd);
      longint t[3];
      longint s[4];
      while (gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_vx <= vx; req_target_vy <= vy; req_target_vz <= vz;
      req_speed_a <= sa; req_speed_b <= sb; req_speed_c <= sc; req_speed_d <= sd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // beat taken at this edge
      t[0] = $signed(vx); t[1] = $signed(vy); t[2] = $signed(vz);
      s[0] = $signed(sa); s[1] = $signed(sb); s[2] = $signed(sc); s[3] = $signed(sd);
      pwm_expected.push_back(predict_pwm(t, s));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pwm_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // CSR write: setup then access, block must be idle
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_PROP:   m_prop = val[15:0];
         REG_INTEG:  m_integ = val[15:0];
         REG_GEOM:   m_geom = val[14:0];
         REG_STEP:   m_step = val[11:0];
         REG_LIMIT:  m_limit = val[14:0];
         REG_FSCALE: m_fs = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] p, i, logic [14:0] g, logic [11:0] st,
                             logic [14:0] l, logic [15:0] f);
      drain();
      csr_write(REG_PROP, {16'hA5A5, p});  // upper bits must be masked
      csr_write(REG_INTEG, 32'(i));
      csr_write(REG_GEOM, 32'(g));
      csr_write(REG_STEP, 32'(st));
      csr_write(REG_LIMIT, 32'(l));
      csr_write(REG_FSCALE, 32'(f));
   endtask

   function automatic logic [15:0] rnd16();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(4000)) - 2000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_ticks(int n);
      logic [15:0] v [3];
      for (int k = 0; k < n; k++) begin
         // hold targets for a run of ticks so the ramp and PI settle
         if (k % 8 == 0) foreach (v[j]) v[j] = ($urandom_range(3) == 0) ? 16'h0 : rnd16();
         if ($urandom_range(9) == 0) v[$urandom_range(2)] = 16'h0;
         send_tick(v[0], v[1], v[2], rnd16(), rnd16(), rnd16(), rnd16());
      end
   endtask

   // directed extremes: saturation, zero target decay, sign flips
   task automatic test_directed();
      send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_tick(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_tick(16'h1000, 16'h0000, 16'hF000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_tick(16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000);
      for (int k = 0; k < 10; k++)
         send_tick(16'h2000, 16'hE000, 16'h1000, 16'h0100, 16'hFF00, 16'h0000, 16'h0000);
      for (int k = 0; k < 4; k++)
         send_tick(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // register extremes: zero gains and full scale, then maxima, then one in every register
   task automatic test_config_extremes();
      set_config(16'd0, 16'd0, 15'd0, 12'd0, 15'd0, 16'd0);
      random_ticks(30);
      set_config(16'hFFFF, 16'hFFFF, 15'h7FFF, 12'hFFF, 15'h7FFF, 16'hFFFF);
      random_ticks(120);
      set_config(16'd1, 16'd1, 15'd1, 12'd1, 15'd1, 16'd1);
      random_ticks(60);
   endtask

   task automatic test_random();
      set_config(PROP_RST, INTEG_RST, GEOM_RST, STEP_RST, LIMIT_RST, FSCALE_RST);
      random_ticks(600);
      // long stretch with no idling, back-to-back ticks
      idle_on = 1'b0;
      random_ticks(300);
      idle_on = 1'b1;
      drain();  // sender holds off until every result is back
      set_config(16'($urandom), 16'($urandom), 15'($urandom), 12'($urandom),
                 15'($urandom), 16'($urandom_range(65535, 1)));
      random_ticks(700);
   endtask

   // result side: random stall, compare each beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            logic [15:0] got [8];
            pwm_beat_type ex;
            got = '{rsp_cmp_a1, rsp_cmp_a2, rsp_cmp_b1, rsp_cmp_b2,
                    rsp_cmp_c1, rsp_cmp_c2, rsp_cmp_d1, rsp_cmp_d2};
            if (pwm_expected.size() == 0) begin
               $display("%0t: unexpected result beat", $time);
               n_errors++;
            end else begin
               ex = pwm_expected.pop_front();
               for (int j = 0; j < 8; j++)
                  if (got[j] !== ex.cmp[j]) begin
                     $display("%0t: cmp[%0d] expected %0d actual %0d", $time, j,
                              ex.cmp[j], got[j]);
                     n_errors++;
                  end
            end
         end
         rsp_stall <= gap();
      end
   end

   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random();
      drain();
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
